/* rtl/assert_macros.svh */
// Assertion macros for the checker module wcg_chk.
// No dependencies; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle -> cons holds in that same cycle
`define WCG_ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("wcg assertion failed");

// ante holds -> cons holds after a delay of dly
`define WCG_ASSERT_DELAY(lbl, ck, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> ##(dly) (cons)) \
    else $error("wcg assertion failed");

`endif

/* rtl/wcg_pkg.sv */
// Types, constants and the quarter-wave cosine table of the window generator.
// No dependencies; used by every other rtl file except assert_macros.svh.
package wcg_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int COEF_BITS  = 16;
  localparam int IDX_W      = 12;
  localparam int LEN_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [LEN_W-1:0] LEN_RESET = 13'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_KIND   = 2'd0,
    REG_WINDOW_LENGTH = 2'd1
  } cfg_reg_t;

  localparam logic KIND_HANN = 1'b0;

  // phase divider: one 32-bit quotient per harmonic, DIV_BITS bits per stage
  localparam int PHASE_W    = 32;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = PHASE_W / DIV_BITS;
  localparam int NUM_HARM   = 3;

  localparam int COS_STAGES  = 3;
  localparam int TAIL_STAGES = COS_STAGES + 3;
  // start to out_valid, in clocks
  localparam int PIPE_DEPTH  = 1 + (DIV_STAGES + 1) + TAIL_STAGES + 1;

  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic signed [31:0] cos_t;

  // quarter-wave table, Q30, 257 entries
  localparam int ROM_ADDR_W = 9;
  localparam int ROM_LAST   = 256;
  localparam int ROM_W      = 31;
  localparam int FOLD_W     = 31;
  localparam int FRAC_W     = 22;
  localparam int DIFF_W     = 23;
  localparam int PROD_W     = DIFF_W + FRAC_W;

  localparam logic [FOLD_W-1:0] QUARTER_TURN = 31'h4000_0000;
  localparam logic [PROD_W-1:0] INTERP_HALF  = PROD_W'(1) << (FRAC_W - 1);

  typedef logic [ROM_LAST:0][ROM_W-1:0] rom_t;

  localparam longint ONE_Q30 = 64'sd1 <<< 30;
  localparam longint ROT_C   = 64'sd1073721611;
  localparam longint ROT_S   = 64'sd6588356;

  // window weights
  localparam logic signed [31:0] HANN_W1 = -32'sd536870912;
  localparam logic signed [31:0] NUT_W1  = -32'sd525250341;
  localparam logic signed [31:0] NUT_W2  = 32'sd146672596;
  localparam logic signed [31:0] NUT_W3  = -32'sd11425794;
  localparam logic signed [63:0] HANN_BASE = 64'sd1 <<< 59;
  localparam logic signed [63:0] NUT_BASE  = 64'sd390393092 <<< 30;

  // Q60 -> Q1.(COEF_BITS-1), round half up, saturate
  localparam int RND_SH = 60 - (COEF_BITS - 1);
  localparam int WQ_W   = 64 - RND_SH;
  localparam logic signed [63:0]        ROUND_HALF = 64'sd1 <<< (RND_SH - 1);
  localparam logic signed [WQ_W-1:0]    WQ_HI = WQ_W'((1 << (COEF_BITS - 1)) - 1);
  localparam logic signed [WQ_W-1:0]    WQ_LO = ~WQ_HI;
  localparam logic [COEF_BITS-1:0]      COEF_HI = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0]      COEF_LO = {1'b1, {(COEF_BITS-1){1'b0}}};

  function automatic longint round_q30(input longint x);
    if (x < 0) begin
      return 0;
    end
    return (x + (ONE_Q30 >>> 1)) >>> 30;
  endfunction

  function automatic rom_t build_cos_rom();
    rom_t   rom;
    longint c;
    longint s;
    longint nc;
    longint ns;
    rom = '0;
    c = ONE_Q30;
    s = 0;
    rom[0] = ROM_W'(c);
    for (int i = 1; i < ROM_LAST; i++) begin
      nc = c * ROT_C - s * ROT_S;
      ns = s * ROT_C + c * ROT_S;
      c = round_q30(nc);
      s = round_q30(ns);
      rom[i] = ROM_W'(c);
    end
    rom[ROM_LAST] = '0;
    return rom;
  endfunction

  localparam rom_t COS_ROM = build_cos_rom();

endpackage

/* rtl/window_coefficient_generator.sv */
// Periodic Hann / symmetric four-term Nuttall window coefficient generator.
// Every accepted start yields one out_valid beat, in order. Throughput: one beat per clock.
// The 16-stage phase divider (two quotient bits per stage, one lane per harmonic) sets depth.
// busy is high only in reset and up to the first edge after it; results cannot be held off.
// Synchronous active-low reset clears valid bits and restores kind Hann, length 64.
module window_coefficient_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [wcg_pkg::IDX_W-1:0]       in_sample_index,
  output logic                            out_valid,
  output logic signed [wcg_pkg::COEF_BITS-1:0] out_coefficient,
  output logic                            out_index_error,
  input  logic                            cfg_we,
  input  logic [wcg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wcg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import wcg_pkg::*;

  function automatic logic [LEN_W-1:0] mod_reduce(input logic [LEN_W+1:0] t,
                                                  input logic [LEN_W-1:0] d);
    logic [LEN_W+1:0] d1;
    logic [LEN_W+1:0] d2;
    logic [LEN_W+1:0] u;
    d1 = {2'b00, d};
    d2 = {1'b0, d, 1'b0};
    u  = (t >= d2) ? (t - d2) : t;
    u  = (u >= d1) ? (u - d1) : u;
    return u[LEN_W-1:0];
  endfunction

  // config
  logic             kind_r;
  logic [LEN_W-1:0] len_r;
  logic             busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_HANN;
      len_r  <= LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_KIND:   kind_r <= cfg_wdata[0];
        REG_WINDOW_LENGTH: len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  logic               accept;
  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   div_d;
  logic [PHASE_W-1:0] num_lo;

  assign accept = start && !busy_r;

  always_comb begin
    len_eff = (len_r > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len_r;
    if (kind_r == KIND_HANN) begin
      div_d = len_eff;
    end else if (len_eff <= LEN_W'(1)) begin
      div_d = LEN_W'(1);
    end else begin
      div_d = len_eff - LEN_W'(1);
    end
    num_lo = PHASE_W'(div_d[LEN_W-1:1]);
  end

  // input stage
  logic             s0_valid_r;
  logic             s0_err_r;
  logic [IDX_W-1:0] s0_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_n_r   <= in_sample_index;
    s0_err_r <= ({1'b0, in_sample_index} >= len_eff);
  end

  // harmonic numerators k*n mod d, then the divider
  logic               div_valid_r [0:DIV_STAGES];
  logic               div_err_r   [0:DIV_STAGES];
  logic [LEN_W-1:0]   div_rem_r   [0:DIV_STAGES][NUM_HARM];
  logic [PHASE_W-1:0] div_q_r     [0:DIV_STAGES][NUM_HARM];

  logic [LEN_W+1:0] t1;
  logic [LEN_W+1:0] t2;
  logic [LEN_W+1:0] t3;

  always_comb begin
    t1 = (LEN_W+2)'(s0_n_r);
    t2 = {2'b00, s0_n_r, 1'b0};
    t3 = t1 + t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_valid_r[0] <= 1'b0;
    end else begin
      div_valid_r[0] <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    div_err_r[0]    <= s0_err_r;
    div_rem_r[0][0] <= mod_reduce(t1, div_d);
    div_rem_r[0][1] <= mod_reduce(t2, div_d);
    div_rem_r[0][2] <= mod_reduce(t3, div_d);
    div_q_r[0][0]   <= '0;
    div_q_r[0][1]   <= '0;
    div_q_r[0][2]   <= '0;
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    logic [LEN_W-1:0]   rem_nxt [NUM_HARM];
    logic [PHASE_W-1:0] q_nxt   [NUM_HARM];

    always_comb begin
      logic [LEN_W:0] t;
      t = '0;
      for (int k = 0; k < NUM_HARM; k++) begin
        rem_nxt[k] = div_rem_r[s-1][k];
        q_nxt[k]   = div_q_r[s-1][k];
        for (int j = 0; j < DIV_BITS; j++) begin
          t = {rem_nxt[k], num_lo[PHASE_W-1-(s-1)*DIV_BITS-j]};
          if (t >= {1'b0, div_d}) begin
            rem_nxt[k] = LEN_W'(t - {1'b0, div_d});
            q_nxt[k]   = {q_nxt[k][PHASE_W-2:0], 1'b1};
          end else begin
            rem_nxt[k] = t[LEN_W-1:0];
            q_nxt[k]   = {q_nxt[k][PHASE_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_valid_r[s] <= 1'b0;
      end else begin
        div_valid_r[s] <= div_valid_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      div_err_r[s] <= div_err_r[s-1];
      div_rem_r[s] <= rem_nxt;
      div_q_r[s]   <= q_nxt;
    end
  end

  // cosine lanes
  cos_t cos_val [NUM_HARM];

  for (genvar k = 0; k < NUM_HARM; k++) begin : g_cos
    wcg_cos u_cos (
      .clk   (clk),
      .phase (div_q_r[DIV_STAGES][k]),
      .cos_q (cos_val[k])
    );
  end

  // valid / error alongside cosine, products and sums
  logic tail_valid_r [TAIL_STAGES];
  logic tail_err_r   [TAIL_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAIL_STAGES; i++) begin
        tail_valid_r[i] <= 1'b0;
      end
    end else begin
      tail_valid_r[0] <= div_valid_r[DIV_STAGES];
      for (int i = 1; i < TAIL_STAGES; i++) begin
        tail_valid_r[i] <= tail_valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    tail_err_r[0] <= div_err_r[DIV_STAGES];
    for (int i = 1; i < TAIL_STAGES; i++) begin
      tail_err_r[i] <= tail_err_r[i-1];
    end
  end

  // weighted harmonics
  logic signed [31:0] wt      [NUM_HARM];
  logic signed [63:0] m_nxt   [NUM_HARM];
  logic signed [63:0] m_r     [NUM_HARM];
  logic signed [63:0] base_sel;

  always_comb begin
    if (kind_r == KIND_HANN) begin
      wt[0]    = HANN_W1;
      wt[1]    = '0;
      wt[2]    = '0;
      base_sel = HANN_BASE;
    end else begin
      wt[0]    = NUT_W1;
      wt[1]    = NUT_W2;
      wt[2]    = NUT_W3;
      base_sel = NUT_BASE;
    end
    for (int k = 0; k < NUM_HARM; k++) begin
      m_nxt[k] = wt[k] * cos_val[k];
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt;
  end

  logic signed [63:0] s01_r;
  logic signed [63:0] s23_r;
  logic signed [63:0] v_r;

  always_ff @(posedge clk) begin
    s01_r <= base_sel + m_r[0];
    s23_r <= m_r[1] + m_r[2];
  end

  always_ff @(posedge clk) begin
    v_r <= s01_r + s23_r;
  end

  // round, saturate, zero on index error, output register
  logic signed [63:0]     rsum;
  logic signed [WQ_W-1:0] wq;
  logic [COEF_BITS-1:0]   coef_nxt;

  always_comb begin
    rsum = v_r + ROUND_HALF;
    wq   = rsum[63:RND_SH];
    if (tail_err_r[TAIL_STAGES-1]) begin
      coef_nxt = '0;
    end else if (wq > WQ_HI) begin
      coef_nxt = COEF_HI;
    end else if (wq < WQ_LO) begin
      coef_nxt = COEF_LO;
    end else begin
      coef_nxt = wq[COEF_BITS-1:0];
    end
  end

  logic                 out_valid_r;
  logic                 out_index_error_r;
  logic [COEF_BITS-1:0] out_coefficient_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r       <= 1'b0;
      out_index_error_r <= 1'b0;
    end else begin
      out_valid_r       <= tail_valid_r[TAIL_STAGES-1];
      out_index_error_r <= tail_valid_r[TAIL_STAGES-1] && tail_err_r[TAIL_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    out_coefficient_r <= coef_nxt;
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_index_error = out_index_error_r;
  assign out_coefficient = $signed(out_coefficient_r);

endmodule

/* rtl/wcg_cos.sv */
// Three-stage cosine of a 32-bit turn phase: fold/lookup, multiply, interp/sign.
// Depends on wcg_pkg (table, widths).
module wcg_cos (
  input  logic            clk,
  input  wcg_pkg::phase_t phase,
  output wcg_pkg::cos_t   cos_q
);
  import wcg_pkg::*;

  logic [1:0]            quad;
  logic [FOLD_W-1:0]     fold;
  logic [ROM_ADDR_W-1:0] idx;
  logic [ROM_W-1:0]      next_ent;
  logic [31:0]           diff_full;
  logic [ROM_W-1:0]      base_nxt;
  logic [DIFF_W-1:0]     diff_nxt;
  logic                  neg_nxt;

  logic [ROM_W-1:0]  base_r;
  logic [DIFF_W-1:0] diff_r;
  logic [FRAC_W-1:0] fr_r;
  logic              neg_r;

  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [ROM_W-1:0]  base2_r;
  logic              neg2_r;

  logic [PROD_W-1:0] step_sum;
  logic [ROM_W-1:0]  mag;
  logic [31:0]       mag_ext;
  cos_t              cos_nxt;
  cos_t              cos_r;

  always_comb begin
    quad    = phase[PHASE_W-1 -: 2];
    fold    = quad[0] ? (QUARTER_TURN - {1'b0, phase[PHASE_W-3:0]})
                      : {1'b0, phase[PHASE_W-3:0]};
    idx     = fold[FOLD_W-1:FRAC_W];
    neg_nxt = quad[0] ^ quad[1];
    if (idx[ROM_ADDR_W-1]) begin
      base_nxt = '0;
      next_ent = '0;
    end else begin
      base_nxt = COS_ROM[idx];
      next_ent = COS_ROM[idx + ROM_ADDR_W'(1)];
    end
    diff_full = {1'b0, base_nxt} - {1'b0, next_ent};
    diff_nxt  = diff_full[31] ? '0 : diff_full[DIFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    diff_r <= diff_nxt;
    fr_r   <= fold[FRAC_W-1:0];
    neg_r  <= neg_nxt;
  end

  assign prod_nxt = diff_r * fr_r;

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    base2_r <= base_r;
    neg2_r  <= neg_r;
  end

  always_comb begin
    step_sum = prod_r + INTERP_HALF;
    mag      = base2_r - {{(ROM_W-DIFF_W){1'b0}}, step_sum[PROD_W-1:FRAC_W]};
    mag_ext  = {1'b0, mag};
    cos_nxt  = neg2_r ? -$signed(mag_ext) : $signed(mag_ext);
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
  end

  assign cos_q = cos_r;

endmodule

/* rtl/wcg_chk.sv */
// Port-level checker for the window coefficient generator, bound to the top level.
// Depends on wcg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wcg_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  out_valid,
  input logic signed [wcg_pkg::COEF_BITS-1:0]  out_coefficient,
  input logic                                  out_index_error
);
  import wcg_pkg::*;

  // every accepted beat comes out after the fixed latency, and only those
  `WCG_ASSERT_DELAY(a_beat_out, clk, rst_n, start && !busy, PIPE_DEPTH, out_valid)
  `WCG_ASSERT_IMPLY(a_beat_src, clk, rst_n, out_valid, $past(start && !busy, PIPE_DEPTH))
  `WCG_ASSERT_IMPLY(a_err_zero, clk, rst_n, out_index_error, out_coefficient == '0)
  `WCG_ASSERT_IMPLY(a_err_valid, clk, rst_n, out_index_error, out_valid)

endmodule

bind window_coefficient_generator wcg_chk u_wcg_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_coefficient (out_coefficient),
  .out_index_error (out_index_error)
);

/* dv/window_coefficient_generator_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of window_coefficient_generator: Hann and Nuttall coefficients.
// Depends on wcg_pkg and the block's rtl; computes expected coefficients on its own.
module window_coefficient_generator_tb;

  localparam int     IDX_W      = wcg_pkg::IDX_W;
  localparam int     CB         = wcg_pkg::COEF_BITS;
  localparam int     MAX_LEN    = wcg_pkg::MAX_LENGTH;
  localparam int     OUT_SHIFT  = 60 - (CB - 1);
  localparam longint COEF_MAX   = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint COEF_MIN   = -(64'sd1 <<< (CB - 1));
  localparam longint Q30_ONE    = 64'sd1 <<< 30;
  localparam longint Q30_HALF   = 64'sd1 <<< 29;
  localparam longint ROT_COS    = 64'sd1073721611;
  localparam longint ROT_SIN    = 64'sd6588356;
  localparam longint NUT_A0     = 64'sd390393092;
  localparam longint NUT_A1     = 64'sd525250341;
  localparam longint NUT_A2     = 64'sd146672596;
  localparam longint NUT_A3     = 64'sd11425794;
  localparam logic   KIND_NUTTALL = 1'b1;
  localparam logic [wcg_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [wcg_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic signed [CB-1:0] coef;
    logic                 index_error;
  } coef_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                start = 1'b0;
  logic                                busy;
  logic [IDX_W-1:0]                    in_sample_index = '0;
  logic                                out_valid;
  logic signed [CB-1:0]                out_coefficient;
  logic                                out_index_error;
  logic                                cfg_we = 1'b0;
  logic [wcg_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [wcg_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;

  window_coefficient_generator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_index (in_sample_index),
    .out_valid       (out_valid),
    .out_coefficient (out_coefficient),
    .out_index_error (out_index_error),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  // shadow copy of the registers
  logic        shadow_kind = wcg_pkg::KIND_HANN;
  logic [12:0] shadow_len  = 13'd64;

  longint       cos_quarter [0:256];
  logic [IDX_W-1:0] index_q [$];
  coef_result_t coef_expect_q [$];

  int  n_sent;
  int  n_done;
  int  n_beats;
  int  n_flagged;
  int  n_errors;
  int  n_settings;
  int  gap_left;
  bit  drain_hold;
  bit  idle_mode;
  bit  beat_taken;

  function automatic void fill_cos_table();
    longint c;
    longint s;
    longint nc;
    longint ns;
    c = Q30_ONE;
    s = 0;
    cos_quarter[0] = c;
    for (int i = 1; i < 256; i++) begin
      nc = c * ROT_COS - s * ROT_SIN;
      ns = s * ROT_COS + c * ROT_SIN;
      c = (nc < 0) ? 0 : ((nc + Q30_HALF) >>> 30);
      s = (ns < 0) ? 0 : ((ns + Q30_HALF) >>> 30);
      cos_quarter[i] = c;
    end
    cos_quarter[256] = 0;
  endfunction

  // x spans [0, 2^30] for [0, pi/2]
  function automatic longint interp_cos(input logic [31:0] x);
    int unsigned idx;
    longint      fr;
    longint      diff;
    idx = x >> 22;
    fr = longint'(x & 32'h003F_FFFF);
    if (idx >= 256) begin
      return 0;
    end
    diff = cos_quarter[idx] - cos_quarter[idx + 1];
    if (diff < 0) begin
      diff = 0;
    end
    return cos_quarter[idx] - ((diff * fr + (64'sd1 <<< 21)) >>> 22);
  endfunction

  function automatic longint cos_of_phase(input logic [31:0] p);
    logic [31:0] r;
    logic [31:0] comp;
    r = {2'b00, p[29:0]};
    comp = 32'h4000_0000 - r;
    case (p[31:30])
      2'd0: return interp_cos(r);
      2'd1: return -interp_cos(comp);
      2'd2: return -interp_cos(r);
      default: return interp_cos(comp);
    endcase
  endfunction

  function automatic logic [31:0] turn_phase(input longint unsigned num,
                                             input longint unsigned den);
    logic [63:0] q;
    q = ((num << 32) + (den >> 1)) / den;
    return q[31:0];
  endfunction

  function automatic coef_result_t predict_window(input logic kind, input logic [12:0] len_reg,
                                                  input logic [IDX_W-1:0] idx);
    longint unsigned n;
    longint unsigned eff_len;
    longint unsigned d;
    logic [31:0]     p1;
    logic [31:0]     p2;
    logic [31:0]     p3;
    longint          v;
    longint          w;
    logic [63:0]     biased;
    coef_result_t    res;
    n = 64'(idx);
    eff_len = 64'(len_reg);
    if (eff_len > MAX_LEN) begin
      eff_len = 64'(MAX_LEN);
    end
    if (n >= eff_len) begin
      res.coef = '0;
      res.index_error = 1'b1;
      return res;
    end
    if (kind == wcg_pkg::KIND_HANN) begin
      v = (64'sd1 <<< 59) - cos_of_phase(turn_phase(n, eff_len)) * (64'sd1 <<< 29);
    end else begin
      d = eff_len - 1;
      p1 = '0;
      p2 = '0;
      p3 = '0;
      if (d != 0) begin
        p1 = turn_phase(n % d, d);
        p2 = turn_phase((2 * n) % d, d);
        p3 = turn_phase((3 * n) % d, d);
      end
      v = NUT_A0 * Q30_ONE - NUT_A1 * cos_of_phase(p1) + NUT_A2 * cos_of_phase(p2)
        - NUT_A3 * cos_of_phase(p3);
    end
    biased = v + (64'sd1 <<< 61) + (64'sd1 <<< (OUT_SHIFT - 1));
    w = longint'(biased >> OUT_SHIFT) - (64'sd1 <<< (61 - OUT_SHIFT));
    if (w > COEF_MAX) begin
      w = COEF_MAX;
    end
    if (w < COEF_MIN) begin
      w = COEF_MIN;
    end
    res.coef = w[CB-1:0];
    res.index_error = 1'b0;
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // beat still pending
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (drain_hold) begin
      start <= 1'b0;
      if (n_done >= n_sent) begin
        drain_hold = 1'b0;
      end
    end else if (index_q.size() > 0) begin
      start <= 1'b1;
      in_sample_index <= index_q.pop_front();
      n_sent++;
      if (idle_mode) begin
        case ($urandom_range(0, 19))
          0, 1:          gap_left = $urandom_range(8, 30);
          2, 3, 4, 5, 6: gap_left = $urandom_range(1, 3);
          default:       gap_left = 0;
        endcase
      end
      if ($urandom_range(0, 59) == 0) begin
        drain_hold = 1'b1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    coef_result_t exp_res;
    beat_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        n_done++;
        if (coef_expect_q.size() == 0) begin
          $display("%0t: unexpected result beat, coefficient %0d index_error %0b",
                   $time, out_coefficient, out_index_error);
          n_errors++;
        end else begin
          exp_res = coef_expect_q.pop_front();
          if (out_coefficient !== exp_res.coef) begin
            $display("%0t: coefficient mismatch, expected %0d, actual %0d",
                     $time, exp_res.coef, out_coefficient);
            n_errors++;
          end
          if (out_index_error !== exp_res.index_error) begin
            $display("%0t: index_error mismatch, expected %0b, actual %0b",
                     $time, exp_res.index_error, out_index_error);
            n_errors++;
          end
        end
      end
      if (start && !busy) begin
        exp_res = predict_window(shadow_kind, shadow_len, in_sample_index);
        coef_expect_q.push_back(exp_res);
        n_beats++;
        if (exp_res.index_error) begin
          n_flagged++;
        end
      end
    end
  end

  task automatic write_reg(input logic [wcg_pkg::CFG_IDX_W-1:0] idx, input logic [12:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      wcg_pkg::REG_WINDOW_KIND:   shadow_kind = data[0];
      wcg_pkg::REG_WINDOW_LENGTH: shadow_len = data;
      default: ;
    endcase
  endtask

  task automatic set_window(input logic kind, input logic [12:0] len);
    logic [11:0] junk;
    junk = 12'($urandom_range(0, 4095));
    write_reg(wcg_pkg::REG_WINDOW_KIND, {junk, kind});
    write_reg(wcg_pkg::REG_WINDOW_LENGTH, len);
    n_settings++;
  endtask

  task automatic wait_idle();
    while (!(index_q.size() == 0 && n_done >= n_sent && !busy)) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int          eff_len;
    int          n_items;
    logic        kind;
    logic [12:0] len;
    fill_cos_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset setting, spare register writes, then extremes and corner lengths
    idle_mode = 1'b0;
    index_q = '{12'd0, 12'd16, 12'd32, 12'd63, 12'd64, 12'd4095};
    wait_idle();
    write_reg(REG_SPARE_2, 13'h1FFF);
    write_reg(REG_SPARE_3, 13'h0001);
    index_q.push_back(12'd1);
    wait_idle();
    set_window(KIND_NUTTALL, 13'd1);
    index_q = '{12'd0, 12'd1};
    wait_idle();
    set_window(KIND_NUTTALL, 13'd2);
    index_q = '{12'd0, 12'd1};
    wait_idle();
    set_window(KIND_NUTTALL, 13'd4096);
    index_q = '{12'd0, 12'd1365, 12'd2048, 12'd4095};
    wait_idle();
    set_window(wcg_pkg::KIND_HANN, 13'd4096);
    index_q = '{12'd1024, 12'd2048, 12'd4095};
    wait_idle();
    set_window(wcg_pkg::KIND_HANN, 13'd0);
    index_q.push_back(12'd0);
    wait_idle();
    set_window(KIND_NUTTALL, 13'd8191);
    index_q = '{12'd4095, 12'd0};
    wait_idle();
    set_window(wcg_pkg::KIND_HANN, 13'd4097);
    index_q.push_back(12'd4095);
    wait_idle();

    // random phases over kinds and lengths
    for (int p = 0; p < 12; p++) begin
      n_items = 34;
      case (p)
        0:  begin kind = wcg_pkg::KIND_HANN; len = 13'd64; end
        1:  begin kind = KIND_NUTTALL; len = 13'd64; end
        2:  begin kind = wcg_pkg::KIND_HANN; len = 13'd4096; end
        3:  begin kind = KIND_NUTTALL; len = 13'd4096; end
        4:  begin kind = wcg_pkg::KIND_HANN; len = 13'd1; end
        5:  begin kind = KIND_NUTTALL; len = 13'd1; end
        6:  begin kind = KIND_NUTTALL; len = 13'd2; end
        7:  begin kind = wcg_pkg::KIND_HANN; len = 13'($urandom_range(3, 300)); end
        8:  begin kind = KIND_NUTTALL; len = 13'($urandom_range(3, 4096)); end
        9:  begin kind = wcg_pkg::KIND_HANN; len = 13'($urandom_range(1, 4096)); end
        10: begin kind = KIND_NUTTALL; len = 13'd8191; end
        default: begin kind = wcg_pkg::KIND_HANN; len = 13'd0; n_items = 10; end
      endcase
      set_window(kind, len);
      eff_len = (len > MAX_LEN) ? MAX_LEN : len;
      idle_mode = (p % 3 != 1);
      for (int i = 0; i < n_items; i++) begin
        if (eff_len > 0 && $urandom_range(0, 99) < 85) begin
          index_q.push_back(IDX_W'($urandom_range(0, eff_len - 1)));
        end else begin
          index_q.push_back(IDX_W'($urandom_range(0, 4095)));
        end
      end
      wait_idle();
    end

    repeat (wcg_pkg::PIPE_DEPTH + 10) @(negedge clk);
    $display("Checked %0d coefficient beats over %0d window settings (Hann and Nuttall),",
             n_beats, n_settings);
    $display("lengths 0 to 8191, %0d of them flagged as out of range.", n_flagged);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
